// ----- sv/priority_ready_queue_assert.svh -----
// assertion macros used by the priority ready queue back end
`ifndef PRIORITY_READY_QUEUE_ASSERT_SVH
`define PRIORITY_READY_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
// plain invariant, checked at every rising clock edge out of reset
`define PRQ_CHK(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("prq invariant violated");
// same-cycle implication
`define PRQ_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prq implication violated");
// next-cycle implication
`define PRQ_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prq sequence violated");
`else
`define PRQ_CHK(lbl, expr)
`define PRQ_IMP(lbl, ante, cons)
`define PRQ_NXT(lbl, ante, cons)
`endif
`endif

// ----- sv/prq_pkg.sv -----
// shared types and codes of the priority ready queue
package prq_pkg;

    // request modes as they arrive on the input channel
    localparam logic [1:0] MODE_INSERT    = 2'd0;
    localparam logic [1:0] MODE_POP_FIRST = 2'd1;
    localparam logic [1:0] MODE_POP_HIGH  = 2'd2;

    // internal operation codes after classification
    typedef logic [1:0] op_t;
    localparam op_t OP_INSERT    = 2'd0;
    localparam op_t OP_POP_FIRST = 2'd1;
    localparam op_t OP_POP_HIGH  = 2'd2;
    localparam op_t OP_NOP       = 2'd3;

    // result status codes
    typedef logic [1:0] status_t;
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    // depth of the command queue between front and back, power of two
    localparam int CMD_FIFO_DEPTH = 2;

    // control part of a queued command
    typedef struct packed {
        logic valid;
        op_t  op;
    } cmd_ctl_t;

endpackage

// ----- sv/prq_req_if.sv -----
// input request channel of the priority ready queue
interface prq_req_if #(
    parameter int ID_BITS   = 16,
    parameter int PRIO_BITS = 8
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           mode;
    logic [ID_BITS-1:0]   proc_id;
    logic [PRIO_BITS-1:0] prio;

    modport source (output valid, mode, proc_id, prio, input ready);
    modport sink   (input valid, mode, proc_id, prio, output ready);
endinterface

// ----- sv/prq_rsp_if.sv -----
// result channel of the priority ready queue
interface prq_rsp_if #(
    parameter int ID_BITS   = 16,
    parameter int PRIO_BITS = 8
);
    logic                 valid;
    logic                 ready;
    logic                 got_entry;
    logic [ID_BITS-1:0]   out_id;
    logic [PRIO_BITS-1:0] out_prio;
    logic                 now_empty;
    logic [1:0]           status;

    modport source (output valid, got_entry, out_id, out_prio, now_empty, status,
                    input ready);
    modport sink   (input valid, got_entry, out_id, out_prio, now_empty, status,
                    output ready);
endinterface

// ----- sv/prq_front.sv -----
// front end: accepts requests, classifies the mode and queues commands
module prq_front #(
    parameter int ID_BITS   = 16,
    parameter int PRIO_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    prq_req_if.sink               req,
    output prq_pkg::cmd_ctl_t     cmd,
    output logic [ID_BITS-1:0]    cmd_id,
    output logic [PRIO_BITS-1:0]  cmd_prio,
    input  logic                  cmd_pop
);

    localparam int FIFO_D  = prq_pkg::CMD_FIFO_DEPTH;
    localparam int FIFO_AW = $clog2(FIFO_D);
    localparam int FCW     = FIFO_AW + 1;

    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FCW-1:0]     cnt_reg, cnt_next;

    prq_pkg::op_t         op_q   [FIFO_D];
    logic [ID_BITS-1:0]   id_q   [FIFO_D];
    logic [PRIO_BITS-1:0] prio_q [FIFO_D];

    logic         push;
    prq_pkg::op_t op_class;

    assign req.ready = (cnt_reg != FCW'(FIFO_D));
    assign push      = req.valid && req.ready;

    // mode decode, unused mode value becomes a no-op
    always_comb
    begin
        unique case (req.mode)
            prq_pkg::MODE_INSERT:    op_class = prq_pkg::OP_INSERT;
            prq_pkg::MODE_POP_FIRST: op_class = prq_pkg::OP_POP_FIRST;
            prq_pkg::MODE_POP_HIGH:  op_class = prq_pkg::OP_POP_HIGH;
            default:                 op_class = prq_pkg::OP_NOP;
        endcase
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !cmd_pop)
        begin
            cnt_next = cnt_reg + FCW'(1);
        end
        else if (!push && cmd_pop)
        begin
            cnt_next = cnt_reg - FCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_q[wr_ptr_reg]   <= op_class;
            id_q[wr_ptr_reg]   <= req.proc_id;
            prio_q[wr_ptr_reg] <= req.prio;
        end
    end

    assign cmd.valid = (cnt_reg != '0);
    assign cmd.op    = op_q[rd_ptr_reg];
    assign cmd_id    = id_q[rd_ptr_reg];
    assign cmd_prio  = prio_q[rd_ptr_reg];

endmodule

// ----- sv/prq_back.sv -----
// back end: entry store, priority scan, gap-closing shift and result register
`include "priority_ready_queue_assert.svh"

module prq_back #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16,
    parameter int PRIO_BITS   = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  prq_pkg::cmd_ctl_t     cmd,
    input  logic [ID_BITS-1:0]    cmd_id,
    input  logic [PRIO_BITS-1:0]  cmd_prio,
    output logic                  cmd_pop,
    prq_rsp_if.source             rsp
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = ID_BITS + PRIO_BITS;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        lim_reg, lim_next;
    logic                 pend_reg, pend_next;
    logic [CW-1:0]        pend_idx_reg, pend_idx_next;
    logic [AW-1:0]        best_idx_reg, best_idx_next;
    logic [ID_BITS-1:0]   best_id_reg, best_id_next;
    logic [PRIO_BITS-1:0] best_prio_reg, best_prio_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_got_reg;
    logic [ID_BITS-1:0]   out_id_reg;
    logic [PRIO_BITS-1:0] out_prio_reg;
    logic                 out_empty_reg;
    prq_pkg::status_t     out_status_reg;

    logic [EW-1:0]        mem [QUEUE_DEPTH];
    logic [EW-1:0]        rd_data_reg;
    logic                 mem_we;
    logic [AW-1:0]        mem_wa;
    logic [EW-1:0]        mem_wd;
    logic [AW-1:0]        mem_ra;

    logic [ID_BITS-1:0]   rd_id;
    logic [PRIO_BITS-1:0] rd_prio;
    logic [CW-1:0]        wr_slot;
    logic                 out_free;
    logic                 shift_done;

    logic                 load;
    logic                 ld_got;
    logic [ID_BITS-1:0]   ld_id;
    logic [PRIO_BITS-1:0] ld_prio;
    logic                 ld_empty;
    prq_pkg::status_t     ld_status;

    assign rd_id      = rd_data_reg[EW-1:PRIO_BITS];
    assign rd_prio    = rd_data_reg[PRIO_BITS-1:0];
    assign wr_slot    = pend_idx_reg - CW'(1);
    assign out_free   = !out_valid_reg || rsp.ready;
    assign shift_done = (state_reg == S_SHIFT) && !pend_reg && !(idx_reg < cnt_reg);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        lim_next       = lim_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        best_idx_next  = best_idx_reg;
        best_id_next   = best_id_reg;
        best_prio_next = best_prio_reg;
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;
        mem_wa         = cnt_reg[AW-1:0];
        mem_wd         = {cmd_id, cmd_prio};
        mem_ra         = idx_reg[AW-1:0];
        load           = 1'b0;
        ld_got         = 1'b0;
        ld_id          = '0;
        ld_prio        = '0;
        ld_empty       = (cnt_reg == '0);
        ld_status      = prq_pkg::ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op) inside
                        prq_pkg::OP_INSERT:
                        begin
                            load = 1'b1;
                            if (cnt_reg == CW'(QUEUE_DEPTH))
                            begin
                                ld_status = prq_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we   = 1'b1;
                                cnt_next = cnt_reg + CW'(1);
                                ld_empty = 1'b0;
                            end
                        end
                        prq_pkg::OP_POP_FIRST, prq_pkg::OP_POP_HIGH:
                        begin
                            if (cnt_reg == '0)
                            begin
                                load      = 1'b1;
                                ld_status = prq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                // oldest-first is a scan over slot 0 only
                                idx_next   = '0;
                                lim_next   = (cmd.op == prq_pkg::OP_POP_HIGH) ?
                                             cnt_reg : CW'(1);
                                pend_next  = 1'b0;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                pend_next = 1'b0;
                if (idx_reg < lim_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg;
                    idx_next      = idx_reg + CW'(1);
                end
                if (pend_reg)
                begin
                    // strict compare keeps the earliest entry on a tie
                    if (pend_idx_reg == '0 || rd_prio > best_prio_reg)
                    begin
                        best_idx_next  = pend_idx_reg[AW-1:0];
                        best_id_next   = rd_id;
                        best_prio_next = rd_prio;
                    end
                    if (pend_idx_reg == lim_reg - CW'(1))
                    begin
                        idx_next   = CW'(best_idx_next) + CW'(1);
                        pend_next  = 1'b0;
                        state_next = S_SHIFT;
                    end
                end
            end
            S_SHIFT:
            begin
                pend_next = 1'b0;
                if (idx_reg < cnt_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg;
                    idx_next      = idx_reg + CW'(1);
                end
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = wr_slot[AW-1:0];
                    mem_wd = rd_data_reg;
                end
                if (shift_done)
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    load       = 1'b1;
                    ld_got     = 1'b1;
                    ld_id      = best_id_reg;
                    ld_prio    = best_prio_reg;
                    ld_empty   = (cnt_reg == CW'(1));
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            lim_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            lim_reg       <= lim_next;
            pend_reg      <= pend_next;
            pend_idx_reg  <= pend_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg  <= best_idx_next;
        best_id_reg   <= best_id_next;
        best_prio_reg <= best_prio_next;
        if (load)
        begin
            out_got_reg    <= ld_got;
            out_id_reg     <= ld_id;
            out_prio_reg   <= ld_prio;
            out_empty_reg  <= ld_empty;
            out_status_reg <= ld_status;
        end
    end

    // entry store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.got_entry = out_got_reg;
    assign rsp.out_id    = out_id_reg;
    assign rsp.out_prio  = out_prio_reg;
    assign rsp.now_empty = out_empty_reg;
    assign rsp.status    = out_status_reg;

    `PRQ_CHK(a_cnt_bound, cnt_reg <= CW'(QUEUE_DEPTH))
    `PRQ_IMP(a_busy_no_result, state_reg != S_IDLE, !out_valid_reg)
    `PRQ_IMP(a_pop_only_idle, cmd_pop, state_reg == S_IDLE && cmd.valid)
    `PRQ_IMP(a_best_in_range, state_reg == S_SHIFT, CW'(best_idx_reg) < cnt_reg)
    `PRQ_NXT(a_take_decrements, shift_done, cnt_reg == $past(cnt_reg) - CW'(1))

endmodule

// ----- sv/priority_ready_queue.sv -----
// top level of the priority ready queue
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+------------------------------------------
//  req     | in  | valid / ready | mode, proc_id, prio
//  rsp     | out | valid / ready | got_entry, out_id, out_prio, now_empty,
//          |     |               | status
//
// insert, no-op and pops of an empty queue load their result straight from the idle state
// pops of a non-empty queue scan, then shift, paced by the single read port of the entry store:
// pop-first scans slot 0 only, pop-highest scans every entry, and the shift moves one slot a cycle
// a two-deep command queue lets the front take requests while the back is busy
// the back end returns to idle once a result is loaded, but takes a new command only when the result register is free
// reset clears the fill count, the sequencer state and the result valid flag, the entry store is not cleared
module priority_ready_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16,
    parameter int PRIO_BITS   = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    prq_req_if.sink   req,
    prq_rsp_if.source rsp
);

    // command handoff between front and back
    prq_pkg::cmd_ctl_t    cmd;
    logic [ID_BITS-1:0]   cmd_id;
    logic [PRIO_BITS-1:0] cmd_prio;
    logic                 cmd_pop;

    // front: request intake, mode decode, command queue
    prq_front #(
        .ID_BITS   (ID_BITS),
        .PRIO_BITS (PRIO_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cmd      (cmd),
        .cmd_id   (cmd_id),
        .cmd_prio (cmd_prio),
        .cmd_pop  (cmd_pop)
    );

    // back: entry store, priority scan, shift and result register
    prq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS),
        .PRIO_BITS   (PRIO_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cmd_id   (cmd_id),
        .cmd_prio (cmd_prio),
        .cmd_pop  (cmd_pop),
        .rsp      (rsp)
    );

endmodule
